@@ hdl/led_pattern_sequencer_core_assert.svh @@
// ----------------------------------------------------------------------------
// led_pattern_sequencer_core_assert.svh
// Assertion macros used by the LED pattern sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lps assertion failed");

`endif

@@ hdl/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// lps_pkg
// Types, codes and the LED byte function of the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned ButtonW  = 5;
  localparam int unsigned LedW     = 8;
  localparam int unsigned PatW     = 3;
  localparam int unsigned StepW    = 8;
  localparam int unsigned TrainLen = 9;
  localparam int unsigned Ph9W     = 4;

  localparam logic [StepW-1:0] StepLast = 8'd143;
  localparam logic [Ph9W-1:0]  Ph9Last  = 4'd8;

  // Command codes.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  typedef enum logic [PatW-1:0] {
    PAT_FWD    = 3'd0,
    PAT_REV    = 3'd1,
    PAT_BLINK  = 3'd2,
    PAT_HALVES = 3'd3,
    PAT_FILL   = 3'd4
  } pattern_e;

  typedef struct packed {
    logic               command;
    logic [ButtonW-1:0] buttons;
  } in_word_t;

  typedef struct packed {
    logic [LedW-1:0] led_bits;
    logic [PatW-1:0] active_pattern;
  } out_word_t;

  localparam logic [LedW-1:0] FwdTrain [TrainLen] = '{
    8'h0F, 8'h1E, 8'h3C, 8'h78, 8'hF0, 8'hE0, 8'hC0, 8'h80, 8'h00
  };
  localparam logic [LedW-1:0] RevTrain [TrainLen] = '{
    8'hF0, 8'h78, 8'h3C, 8'h1E, 8'h0F, 8'h07, 8'h03, 8'h01, 8'h00
  };

  // LED byte for a pattern; ph9 is the step modulo 9, ph16 the step modulo 16.
  function automatic logic [LedW-1:0] led_byte(pattern_e pat, logic [Ph9W-1:0] ph9,
                                               logic [3:0] ph16);
    logic [LedW:0]   wide;
    logic [3:0]      shamt;
    logic [LedW-1:0] res;
    wide  = '0;
    shamt = '0;
    res   = '0;
    case (pat)
      PAT_FWD:    res = FwdTrain[ph9];
      PAT_REV:    res = RevTrain[ph9];
      PAT_BLINK:  res = ph16[0] ? 8'h55 : 8'hAA;
      PAT_HALVES: res = ph16[0] ? 8'hF0 : 8'h0F;
      PAT_FILL: begin
        if (!ph16[3]) begin
          // fill: low phase+1 bits set
          res = 8'hFF >> (3'd7 - ph16[2:0]);
        end else begin
          // empty: shift out phase-7 bits
          shamt = {1'b0, ph16[2:0]} + 4'd1;
          wide  = 9'h0FF >> shamt;
          res   = wide[LedW-1:0];
        end
      end
      default:    res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/lps_if.sv @@
// ----------------------------------------------------------------------------
// lps_cmd_if / lps_led_if
// Valid/ready channels carrying command words in and LED words out.
// ----------------------------------------------------------------------------
interface lps_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [4:0] buttons;

  modport source (output valid, output command, output buttons, input ready);
  modport sink   (input valid, input command, input buttons, output ready);
endinterface

interface lps_led_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_bits;
  logic [2:0] active_pattern;

  modport source (output valid, output led_bits, output active_pattern, input ready);
  modport sink   (input valid, input led_bits, input active_pattern, output ready);
endinterface

@@ hdl/lps_in_reg.sv @@
// ----------------------------------------------------------------------------
// lps_in_reg
// Input register: holds one command word until the animator consumes it.
// ----------------------------------------------------------------------------
module lps_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  lps_pkg::in_word_t word_i,
  output logic             valid_o,
  input  logic             take_i,
  output lps_pkg::in_word_t word_o
);

  logic              valid_q, valid_d;
  lps_pkg::in_word_t word_q, word_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        word_d = word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ hdl/lps_animator.sv @@
// ----------------------------------------------------------------------------
// lps_animator
// Pattern selection and step state; forms the LED word for each tick.
// ----------------------------------------------------------------------------
`include "led_pattern_sequencer_core_assert.svh"

module lps_animator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lps_pkg::in_word_t  word_i,
  input  logic               out_ready_i,
  output logic               take_o,
  output logic               load_o,
  output lps_pkg::out_word_t word_o
);

  lps_pkg::pattern_e         chosen_q, chosen_d;
  lps_pkg::pattern_e         shown_q, shown_d;
  logic [lps_pkg::StepW-1:0] step_q, step_d, cur_step;
  logic [lps_pkg::Ph9W-1:0]  ph9_q, ph9_d, cur_ph9;
  logic                      is_tick, is_button, restart;

  assign is_tick   = valid_i && (word_i.command == lps_pkg::CMD_TICK);
  assign is_button = valid_i && (word_i.command == lps_pkg::CMD_BUTTON);

  // Buttons never wait; ticks wait for room in the output register.
  assign take_o = is_button || (is_tick && out_ready_i);
  assign load_o = is_tick && out_ready_i;

  // Restart the step when the pattern changed since the last tick.
  assign restart  = (chosen_q != shown_q);
  assign cur_step = restart ? '0 : step_q;
  assign cur_ph9  = restart ? '0 : ph9_q;

  always_comb begin
    chosen_d = chosen_q;
    if (is_button) begin
      if (word_i.buttons[0]) begin
        chosen_d = lps_pkg::PAT_FWD;
      end else if (word_i.buttons[1]) begin
        chosen_d = lps_pkg::PAT_REV;
      end else if (word_i.buttons[2]) begin
        chosen_d = lps_pkg::PAT_BLINK;
      end else if (word_i.buttons[3]) begin
        chosen_d = lps_pkg::PAT_HALVES;
      end else if (word_i.buttons[4]) begin
        chosen_d = lps_pkg::PAT_FILL;
      end
    end
  end

  always_comb begin
    shown_d = shown_q;
    step_d  = step_q;
    ph9_d   = ph9_q;
    if (load_o) begin
      shown_d = chosen_q;
      step_d  = (cur_step == lps_pkg::StepLast) ? '0 : cur_step + 1'b1;
      ph9_d   = (cur_ph9 == lps_pkg::Ph9Last) ? '0 : cur_ph9 + 1'b1;
    end
  end

  assign word_o.led_bits       = lps_pkg::led_byte(chosen_q, cur_ph9, cur_step[3:0]);
  assign word_o.active_pattern = chosen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chosen_q <= lps_pkg::PAT_FWD;
      shown_q  <= lps_pkg::PAT_FWD;
      step_q   <= '0;
      ph9_q    <= '0;
    end else begin
      chosen_q <= chosen_d;
      shown_q  <= shown_d;
      step_q   <= step_d;
      ph9_q    <= ph9_d;
    end
  end

  `LPS_ASSERT_NOW(a_step_range, clk_i, rst_ni, 1'b1, step_q <= lps_pkg::StepLast)
  `LPS_ASSERT_NOW(a_ph9_range, clk_i, rst_ni, 1'b1, ph9_q <= lps_pkg::Ph9Last)
  `LPS_ASSERT_NOW(a_step_ph9_sync, clk_i, rst_ni, step_q == '0, ph9_q == '0)
  `LPS_ASSERT_NEXT(a_tick_shows_choice, clk_i, rst_ni, load_o, shown_q == $past(chosen_q))

endmodule

@@ hdl/lps_out_reg.sv @@
// ----------------------------------------------------------------------------
// lps_out_reg
// Output register: holds the LED word until the receiver takes it.
// ----------------------------------------------------------------------------
module lps_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  lps_pkg::out_word_t word_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output lps_pkg::out_word_t word_o
);

  logic               valid_q, valid_d;
  lps_pkg::out_word_t word_q, word_d;

  assign room_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (room_o) begin
      valid_d = load_i;
      if (load_i) begin
        word_d = word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ hdl/led_pattern_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// led_pattern_sequencer_core
// Eight-LED animation sequencer with five button-selected patterns.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command word per handshake: command = 0 is an animation
//   tick, command = 1 a button event whose lowest set button bit picks the
//   pattern (no bit set: no change). A button word yields no output word.
//   Each tick yields one word on led_o: the LED byte and the pattern shown.
//   A tick after a pattern change restarts the animation at step 0; the step
//   wraps after 144 ticks.
// Timing:
//   A word sits in the input register from the edge that accepts it; from
//   there a tick's result moves into the output register, which raises led_o
//   valid. One word is accepted per cycle while cmd_i ready is high.
// Reset:
//   Both registers empty, forward train selected and shown, step 0.
// Stall:
//   While led_o is stalled and the output register is full, a tick holds in
//   the input register and cmd_i ready drops until led_o takes its word;
//   button words need no output room and keep flowing until a tick blocks.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lps_cmd_if.sink   cmd_i,
  lps_led_if.source led_o
);

  lps_pkg::in_word_t  in_word, held_word;
  lps_pkg::out_word_t next_word, out_word;
  logic               held_valid, take, load, room;

  // Pack the command channel payload.
  assign in_word.command = cmd_i.command;
  assign in_word.buttons = cmd_i.buttons;

  // Stage 1: capture the command word.
  lps_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_i.valid),
    .ready_o (cmd_i.ready),
    .word_i  (in_word),
    .valid_o (held_valid),
    .take_i  (take),
    .word_o  (held_word)
  );

  // Pattern and step state; builds the LED word for a tick.
  lps_animator u_animator (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .word_i      (held_word),
    .out_ready_i (room),
    .take_o      (take),
    .load_o      (load),
    .word_o      (next_word)
  );

  // Stage 2: hold the result until led_o takes it.
  lps_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .word_i  (next_word),
    .room_o  (room),
    .valid_o (led_o.valid),
    .ready_i (led_o.ready),
    .word_o  (out_word)
  );

  assign led_o.led_bits       = out_word.led_bits;
  assign led_o.active_pattern = out_word.active_pattern;

endmodule
